// File: hw/rtl/ttce_pkg.sv
`default_nettype none

package ttce_pkg;

    // Geometry of the terminals.
    localparam int COLS      = 80;
    localparam int ROWS      = 25;
    localparam int TERMINALS = 8;

    localparam int CELLS  = ROWS * COLS;
    localparam int TOTAL  = TERMINALS * CELLS;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int CNT_W  = $clog2(TOTAL + 1);
    localparam int TIDX_W = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

    // Field widths of the transaction ports.
    localparam int FUNC_W = 2;
    localparam int TERM_W = 3;
    localparam int CH_W   = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;

    // Function codes.
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Character codes.
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_BS    = 8'h08;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam int              TAB_STOP = 8;

    typedef logic [ADDR_W-1:0] addr_t;

    // Linear store address of one cell.
    function automatic addr_t cell_addr(input logic [TIDX_W-1:0] t,
                                        input logic [ROW_W-1:0] r,
                                        input logic [COL_W-1:0] c);
        cell_addr = ADDR_W'(t) * ADDR_W'(CELLS) + ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/text_terminal_cell_engine.sv
// Results: put character, control codes, unused codes and a bad terminal give their result
// in the cycle after the start edge; a cell read goes through the registered store read and
// the READ state; a clear and a put that scrolls walk a terminal's cells through the single
// store write port. Throughput: a non-scrolling put per cycle; a read keeps busy high until
// its result, and the receiver cannot stall. Reset: cursors go to the origin, then a
// clearing pass writes spaces to all TERMINALS*ROWS*COLS cells while busy stays high.
`default_nettype none

module text_terminal_cell_engine (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [ttce_pkg::FUNC_W-1:0]    func,
    input  wire logic [ttce_pkg::TERM_W-1:0]    term_sel,
    input  wire logic [ttce_pkg::CH_W-1:0]      ch,
    input  wire logic [ttce_pkg::ROW_W-1:0]     read_row,
    input  wire logic [ttce_pkg::COL_W-1:0]     read_col,
    output logic                                done,
    output logic [ttce_pkg::COL_W-1:0]          cursor_col,
    output logic [ttce_pkg::ROW_W-1:0]          cursor_row,
    output logic [ttce_pkg::CH_W-1:0]           cell_char,
    output logic                                scrolled
);
    import ttce_pkg::*;

    // Sequencer states. INIT is the clearing pass after reset, CLEAR blanks one terminal,
    // SCROLL moves one terminal's rows up by one and blanks the bottom row, READ waits for
    // the store's registered read data.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_INIT   = 3'd1;
    localparam logic [2:0] ST_CLEAR  = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    addr_t            base_reg, base_next;

    // Per-terminal cursors. They are few and read at a single place, so they live in
    // flip-flops; all cell contents live in the synchronous store below.
    logic [COL_W-1:0] col_reg [TERMINALS];
    logic [ROW_W-1:0] row_reg [TERMINALS];
    logic             cur_we;
    logic [COL_W-1:0] cur_col_new;
    logic [ROW_W-1:0] cur_row_new;

    // Result registers.
    logic             done_reg, done_next;
    logic [COL_W-1:0] ocol_reg, ocol_next;
    logic [ROW_W-1:0] orow_reg, orow_next;
    logic [CH_W-1:0]  ochar_reg, ochar_next;
    logic             oscr_reg, oscr_next;

    // Cell store: one write port and one read port, read data registered.
    logic [CH_W-1:0]  mem_cells [TOTAL];
    logic             mem_we, mem_re;
    addr_t            mem_waddr, mem_raddr;
    logic [CH_W-1:0]  mem_wdata;
    logic [CH_W-1:0]  rdata_reg;

    // Decode of the incoming transaction.
    logic             accept;
    logic             term_ok;
    logic [TIDX_W-1:0] tidx;
    logic [COL_W-1:0] cx;
    logic [ROW_W-1:0] cy;
    logic [COL_W:0]   tab_sum, tab_al;
    logic [COL_W-1:0] nx;
    logic [ROW_W-1:0] ny;
    logic             put_wr;
    logic [COL_W-1:0] put_wcol;
    logic [ROW_W-1:0] put_wrow;
    logic [CH_W-1:0]  put_wch;
    logic             put_scroll;
    logic             at_last_row;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign term_ok = (int'(term_sel) < TERMINALS);
    assign tidx   = TIDX_W'(term_sel);
    assign cx     = col_reg[tidx];
    assign cy     = row_reg[tidx];
    assign at_last_row = (cy == ROW_W'(ROWS - 1));
    assign tab_sum = {1'b0, cx} + (COL_W + 1)'(TAB_STOP);
    assign tab_al  = tab_sum & ~((COL_W + 1)'(TAB_STOP - 1));

    // Cursor motion and the cell write of a put character.
    always_comb
    begin
        nx         = cx;
        ny         = cy;
        put_wr     = 1'b0;
        put_wcol   = cx;
        put_wrow   = cy;
        put_wch    = ch;
        put_scroll = 1'b0;
        unique case (ch)
            CH_LF:
            begin
                nx = '0;
                if (at_last_row)
                    put_scroll = 1'b1;
                else
                    ny = cy + ROW_W'(1);
            end
            CH_BS:
            begin
                if (cx != '0 || cy != '0)
                begin
                    if (cx == '0)
                    begin
                        ny = cy - ROW_W'(1);
                        nx = COL_W'(COLS - 1);
                    end
                    else
                    begin
                        nx = cx - COL_W'(1);
                    end
                    put_wr   = 1'b1;
                    put_wcol = nx;
                    put_wrow = ny;
                    put_wch  = CH_SPACE;
                end
            end
            CH_TAB:
            begin
                // Tab stops saturate at the last column instead of wrapping.
                if (tab_al > (COL_W + 1)'(COLS - 1))
                    nx = COL_W'(COLS - 1);
                else
                    nx = tab_al[COL_W-1:0];
            end
            CH_CR:
            begin
                nx = '0;
            end
            default:
            begin
                put_wr = 1'b1;
                if (cx < COL_W'(COLS - 1))
                begin
                    nx = cx + COL_W'(1);
                end
                else
                begin
                    nx = '0;
                    if (at_last_row)
                        put_scroll = 1'b1;
                    else
                        ny = cy + ROW_W'(1);
                end
            end
        endcase
    end

    // Sequencer and store port control.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        base_next   = base_reg;
        done_next   = 1'b0;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        ochar_next  = ochar_reg;
        oscr_next   = oscr_reg;
        cur_we      = 1'b0;
        cur_col_new = nx;
        cur_row_new = ny;
        mem_we      = 1'b0;
        mem_waddr   = base_reg + ADDR_W'(cnt_reg);
        mem_wdata   = CH_SPACE;
        mem_re      = 1'b0;
        mem_raddr   = cell_addr(tidx, read_row, read_col);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ocol_next  = cx;
                    orow_next  = cy;
                    ochar_next = '0;
                    oscr_next  = 1'b0;
                    done_next  = 1'b1;
                    if (!term_ok)
                    begin
                        ocol_next = '0;
                        orow_next = '0;
                    end
                    else
                    begin
                        unique case (func)
                            FUNC_PUT:
                            begin
                                cur_we    = 1'b1;
                                ocol_next = nx;
                                orow_next = ny;
                                oscr_next = put_scroll;
                                mem_we    = put_wr;
                                mem_waddr = cell_addr(tidx, put_wrow, put_wcol);
                                mem_wdata = put_wch;
                                if (put_scroll)
                                begin
                                    done_next  = 1'b0;
                                    cnt_next   = '0;
                                    base_next  = cell_addr(tidx, '0, '0);
                                    state_next = ST_SCROLL;
                                end
                            end
                            FUNC_CLEAR:
                            begin
                                done_next  = 1'b0;
                                cnt_next   = '0;
                                base_next  = cell_addr(tidx, '0, '0);
                                state_next = ST_CLEAR;
                            end
                            FUNC_READ:
                            begin
                                if (int'(read_row) < ROWS && int'(read_col) < COLS)
                                begin
                                    done_next  = 1'b0;
                                    mem_re     = 1'b1;
                                    state_next = ST_READ;
                                end
                            end
                            default:
                            begin
                                // Unused code: report the cursor and change nothing.
                            end
                        endcase
                    end
                end
            end
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(cnt_reg);
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TOTAL - 1))
                    state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCROLL:
            begin
                // Step n reads the cell one row below cell n and writes the data read in
                // the previous step to cell n-1; the bottom row is written with spaces.
                mem_re    = (cnt_reg < CNT_W'(CELLS - COLS));
                mem_raddr = base_reg + ADDR_W'(cnt_reg) + ADDR_W'(COLS);
                mem_we    = (cnt_reg != '0);
                mem_waddr = base_reg + ADDR_W'(cnt_reg) - ADDR_W'(1);
                mem_wdata = (cnt_reg <= CNT_W'(CELLS - COLS)) ? rdata_reg : CH_SPACE;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CELLS))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                ochar_next = rdata_reg;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
            base_reg  <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < TERMINALS; i++)
            begin
                col_reg[i] <= '0;
                row_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            base_reg  <= base_next;
            done_reg  <= done_next;
            if (cur_we)
            begin
                col_reg[tidx] <= cur_col_new;
                row_reg[tidx] <= cur_row_new;
            end
        end
    end

    // Result payload needs no reset; it is qualified by done.
    always_ff @(posedge clk)
    begin
        ocol_reg  <= ocol_next;
        orow_reg  <= orow_next;
        ochar_reg <= ochar_next;
        oscr_reg  <= oscr_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_cells[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem_cells[mem_raddr];
    end

    assign done       = done_reg;
    assign cursor_col = ocol_reg;
    assign cursor_row = orow_reg;
    assign cell_char  = ochar_reg;
    assign scrolled   = oscr_reg;

    // Every accepted transaction either answers in the next cycle or keeps the block busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done || busy))
        else $error("accepted transaction neither answered nor in progress");

    // A reported cursor always lies inside the screen.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (int'(cursor_row) < ROWS && int'(cursor_col) < COLS))
        else $error("reported cursor outside the screen");

    // A scroll always leaves the cursor at the start of the bottom row.
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && scrolled) |-> (cursor_row == ROW_W'(ROWS - 1) && cursor_col == '0))
        else $error("scroll left the cursor off the bottom row start");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps

// Testbench for the character-cell text terminal engine.
//
// Every transaction that the engine accepts is run at once through a model of
// the terminals that lives in this file: a copy of all cell stores and cursors.
// The model's answer goes into a queue, and a monitor compares each result
// strobe with the oldest entry, field by field. The engine returns exactly one
// result per transaction, in order, so a plain FIFO is enough.
//
// The run starts with short directed tests for the corners of the cursor logic
// and then sends random text lines. Lines are the well-formed traffic of a
// terminal. One terminal receives most of them, so that its cursor reaches the
// bottom row and each later line feed or wrap scrolls the store.
module testbench;

    import ttce_pkg::*;

    // The engine defines no operation for the fourth function code.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1600;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [CH_W-1:0]  cell_val;
        logic             scrolled;
    } term_result_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [FUNC_W-1:0] func;
    logic [TERM_W-1:0] term_sel;
    logic [CH_W-1:0]   ch;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
    logic              done;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [CH_W-1:0]   cell_char;
    logic              scrolled;

    // Model state: every cell of every terminal and each terminal's cursor.
    logic [CH_W-1:0]  screen_cells [TERMINALS][ROWS][COLS];
    logic [COL_W-1:0] cursor_cols [TERMINALS];
    logic [ROW_W-1:0] cursor_rows [TERMINALS];

    term_result_t expected_results [$];
    term_result_t observed;
    term_result_t wanted;

    int  mismatch_count = 0;
    int  items_issued   = 0;
    bit  gaps_on        = 1'b1;

    text_terminal_cell_engine i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .term_sel   (term_sel),
        .ch         (ch),
        .read_row   (read_row),
        .read_col   (read_col),
        .done       (done),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .cell_char  (cell_char),
        .scrolled   (scrolled)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Terminal model
    // ------------------------------------------------------------------

    // Moves the cursor one row down. Past the last row the terminal's rows move
    // up by one, the bottom row is blanked and the cursor stays on the
    // bottom row. Returns 1 when that scroll happened.
    function automatic logic advance_row(input int t);
        if (int'(cursor_rows[t]) + 1 < ROWS)
        begin
            cursor_rows[t] = cursor_rows[t] + 1'b1;
            return 1'b0;
        end
        for (int r = 0; r < ROWS - 1; r++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                screen_cells[t][r][c] = screen_cells[t][r + 1][c];
            end
        end
        for (int c = 0; c < COLS; c++)
        begin
            screen_cells[t][ROWS - 1][c] = CH_SPACE;
        end
        cursor_rows[t] = ROW_W'(ROWS - 1);
        return 1'b1;
    endfunction

    // Applies one accepted transaction to the model and returns the result
    // that the engine has to report for it.
    function automatic term_result_t apply_terminal_item(input logic [FUNC_W-1:0] f,
                                                         input logic [TERM_W-1:0] t,
                                                         input logic [CH_W-1:0]   c,
                                                         input logic [ROW_W-1:0]  rr,
                                                         input logic [COL_W-1:0]  rc);
        term_result_t res;
        int x;
        int y;
        logic scroll_hit;

        res = '0;
        scroll_hit = 1'b0;
        // A terminal that does not exist gives an all-zero result.
        if (int'(t) >= TERMINALS)
        begin
            return res;
        end
        x = int'(cursor_cols[t]);
        y = int'(cursor_rows[t]);
        case (f)
            FUNC_PUT:
            begin
                case (c)
                    CH_LF:
                    begin
                        scroll_hit = advance_row(t);
                        cursor_cols[t] = '0;
                    end
                    CH_BS:
                    begin
                        // At the origin there is nothing to step back over.
                        if (x != 0 || y != 0)
                        begin
                            if (x == 0)
                            begin
                                y = y - 1;
                                x = COLS - 1;
                            end
                            else
                            begin
                                x = x - 1;
                            end
                            cursor_cols[t] = COL_W'(x);
                            cursor_rows[t] = ROW_W'(y);
                            screen_cells[t][y][x] = CH_SPACE;
                        end
                    end
                    CH_TAB:
                    begin
                        // Next tab stop, held at the last column instead of wrapping.
                        x = (x + TAB_STOP) & ~(TAB_STOP - 1);
                        if (x > COLS - 1)
                        begin
                            x = COLS - 1;
                        end
                        cursor_cols[t] = COL_W'(x);
                    end
                    CH_CR:
                    begin
                        cursor_cols[t] = '0;
                    end
                    default:
                    begin
                        screen_cells[t][y][x] = c;
                        if (x < COLS - 1)
                        begin
                            cursor_cols[t] = COL_W'(x + 1);
                        end
                        else
                        begin
                            cursor_cols[t] = '0;
                            scroll_hit = advance_row(t);
                        end
                    end
                endcase
            end
            FUNC_CLEAR:
            begin
                // Only the cells are blanked; the cursor stays where it was.
                for (int r = 0; r < ROWS; r++)
                begin
                    for (int k = 0; k < COLS; k++)
                    begin
                        screen_cells[t][r][k] = CH_SPACE;
                    end
                end
            end
            FUNC_READ:
            begin
                if (int'(rr) < ROWS && int'(rc) < COLS)
                begin
                    res.cell_val = screen_cells[t][rr][rc];
                end
            end
            default:
            begin
            end
        endcase
        res.col = cursor_cols[t];
        res.row = cursor_rows[t];
        res.scrolled = scroll_hit;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Sends one transaction and waits until the engine takes it. Start stays
    // high afterwards, so that back-to-back transactions follow without a gap;
    // the next call or the final drain decides what start does next.
    task automatic issue_item(input logic [FUNC_W-1:0] f,
                              input logic [TERM_W-1:0] t,
                              input logic [CH_W-1:0]   c,
                              input logic [ROW_W-1:0]  rr,
                              input logic [COL_W-1:0]  rc);
        if (gaps_on && $urandom_range(0, 99) < 10)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start    <= 1'b1;
        func     <= f;
        term_sel <= t;
        ch       <= c;
        read_row <= rr;
        read_col <= rc;
        @(posedge clk);
        // Busy is read before the engine's own updates at this edge, so it is
        // the value the engine saw when it decided to take the transaction.
        while (busy)
        begin
            @(posedge clk);
        end
        expected_results.push_back(apply_terminal_item(f, t, c, rr, rc));
        items_issued++;
    endtask

    // The wrappers fill the fields that an operation ignores with noise.
    task automatic put_char(input logic [TERM_W-1:0] t, input logic [CH_W-1:0] c);
        issue_item(FUNC_PUT, t, c, ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic read_cell(input logic [TERM_W-1:0] t,
                             input logic [ROW_W-1:0] r,
                             input logic [COL_W-1:0] c);
        issue_item(FUNC_READ, t, CH_W'($urandom), r, c);
    endtask

    task automatic clear_terminal(input logic [TERM_W-1:0] t);
        issue_item(FUNC_CLEAR, t, CH_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
    endtask

    // One line of text: printable characters with the odd tab, backspace or
    // raw byte mixed in, mostly ended by a line feed. Some lines are longer
    // than a row so that the cursor wraps.
    task automatic send_text_line(input logic [TERM_W-1:0] t);
        int len;
        int pick;
        logic [CH_W-1:0] c;

        if ($urandom_range(0, 9) == 0)
        begin
            len = $urandom_range(70, 100);
        end
        else
        begin
            len = $urandom_range(0, 14);
        end
        for (int k = 0; k < len; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                c = CH_TAB;
            end
            else if (pick < 6)
            begin
                c = CH_BS;
            end
            else if (pick < 10)
            begin
                c = CH_W'($urandom_range(0, 255));
            end
            else
            begin
                c = CH_W'($urandom_range(8'h20, 8'h7E));
            end
            put_char(t, c);
        end
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            put_char(t, CH_LF);
        end
        else if (pick < 85)
        begin
            put_char(t, CH_CR);
            put_char(t, CH_LF);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // After the clearing pass every cell reads as a space; reads outside the
    // screen give zero.
    task automatic test_after_reset();
        read_cell(3'd0, 5'd0, 7'd0);
        read_cell(3'd7, ROW_W'(ROWS - 1), COL_W'(COLS - 1));
        read_cell(3'd0, ROW_W'(ROWS), 7'd0);
        read_cell(3'd0, 5'd0, COL_W'(COLS));
        read_cell(3'd0, 5'h1F, 7'h7F);
    endtask

    // Backspace at the origin, the extreme bytes, tab, carriage return and
    // line feed.
    task automatic test_controls();
        put_char(3'd0, CH_BS);
        put_char(3'd0, 8'h00);
        put_char(3'd0, 8'hFF);
        read_cell(3'd0, 5'd0, 7'd1);
        put_char(3'd0, CH_TAB);
        put_char(3'd0, CH_CR);
        put_char(3'd0, CH_LF);
    endtask

    // A backspace at column 0 wraps to the last column of the row above; a
    // tab there saturates, and a character in the last column wraps down.
    task automatic test_wrap_and_tab();
        put_char(3'd0, CH_BS);
        put_char(3'd0, CH_TAB);
        put_char(3'd0, 8'h41);
        read_cell(3'd0, 5'd0, COL_W'(COLS - 1));
        put_char(3'd7, 8'h5A);
    endtask

    // The unused function code changes nothing, and a clear keeps the cursor.
    task automatic test_clear_and_unused();
        issue_item(FUNC_UNUSED, 3'd0, 8'hA5, 5'd0, 7'd1);
        clear_terminal(3'd0);
        read_cell(3'd0, 5'd0, 7'd1);
        read_cell(3'd7, 5'd0, 7'd0);
    endtask

    // Random traffic, mostly text lines. One terminal takes about half the
    // lines so that it reaches the bottom row and keeps scrolling.
    task automatic test_random_lines();
        int first_item;
        int done_items;
        int pick;
        int n;
        logic [TERM_W-1:0] hot_term;
        logic [TERM_W-1:0] t;

        first_item = items_issued;
        done_items = 0;
        hot_term = TERM_W'($urandom_range(0, TERMINALS - 1));
        while (done_items < RANDOM_ITEMS)
        begin
            // A long stretch in the middle runs with start held high throughout.
            gaps_on = !(done_items >= 600 && done_items < 1000);
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 1) == 0)
            begin
                t = hot_term;
            end
            else
            begin
                t = TERM_W'($urandom_range(0, TERMINALS - 1));
            end
            if (pick < 80)
            begin
                send_text_line(t);
            end
            else if (pick < 92)
            begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                begin
                    if ($urandom_range(0, 99) < 15)
                    begin
                        read_cell(t, ROW_W'($urandom), COL_W'($urandom));
                    end
                    else if ($urandom_range(0, 1) == 0)
                    begin
                        // Aim at the row just written, where a slip shows first.
                        read_cell(t, cursor_rows[t],
                                  COL_W'($urandom_range(0, cursor_cols[t])));
                    end
                    else
                    begin
                        read_cell(t, ROW_W'($urandom_range(0, ROWS - 1)),
                                  COL_W'($urandom_range(0, COLS - 1)));
                    end
                end
            end
            else if (pick < 98)
            begin
                issue_item(FUNC_W'($urandom_range(0, 3)), TERM_W'($urandom),
                           CH_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
            end
            else
            begin
                clear_terminal(t);
            end
            done_items = items_issued - first_item;
        end
        gaps_on = 1'b1;
    endtask

    // Lowers start and waits until every expected result has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string field, input int exp_v, input int act_v);
        mismatch_count++;
        $display("%0t ns: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                 $time, field, exp_v, exp_v, act_v, act_v);
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            observed = '{cursor_col, cursor_row, cell_char, scrolled};
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result", 0, int'(observed));
            end
            else
            begin
                wanted = expected_results.pop_front();
                if (observed.col !== wanted.col)
                begin
                    report_mismatch("cursor_col", int'(wanted.col), int'(observed.col));
                end
                if (observed.row !== wanted.row)
                begin
                    report_mismatch("cursor_row", int'(wanted.row), int'(observed.row));
                end
                if (observed.cell_val !== wanted.cell_val)
                begin
                    report_mismatch("cell_char", int'(wanted.cell_val),
                                    int'(observed.cell_val));
                end
                if (observed.scrolled !== wanted.scrolled)
                begin
                    report_mismatch("scrolled", int'(wanted.scrolled),
                                    int'(observed.scrolled));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        for (int t = 0; t < TERMINALS; t++)
        begin
            cursor_cols[t] = '0;
            cursor_rows[t] = '0;
            for (int r = 0; r < ROWS; r++)
            begin
                for (int c = 0; c < COLS; c++)
                begin
                    screen_cells[t][r][c] = CH_SPACE;
                end
            end
        end
        rst_n    <= 1'b0;
        start    <= 1'b0;
        func     <= FUNC_PUT;
        term_sel <= '0;
        ch       <= '0;
        read_row <= '0;
        read_col <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // The engine holds busy through its clearing pass; the first
        // transaction simply waits for it.
        test_after_reset();
        test_controls();
        test_wrap_and_tab();
        test_clear_and_unused();
        test_random_lines();

        wait_for_results();
        // Every transaction yields a result, so only a short settle is needed
        // to catch a stray extra strobe.
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Hard limit: far beyond a run in which every transaction took the full
    // length of a clear or a scroll, plus the clearing pass after reset.
    initial
    begin
        #60000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
